// ----- hw/rtl/spdv_pkg.sv -----
// Package: payload types and constants for the stereo pan and distance volume block.
`timescale 1ns / 1ps
package spdv_pkg;
	localparam int POS_W = 24;
	localparam int AX_W = 16;
	localparam int GF = 16;
	localparam int GW = GF + 1;
	localparam int PF = 22;
	localparam int DW = POS_W + 1;
	localparam int PRW = DW + AX_W + 2;
	localparam logic [GW-1:0] ONE = GW'(1) << GF;

	typedef struct packed {
		logic signed [POS_W-1:0] src_x;
		logic signed [POS_W-1:0] src_y;
		logic signed [POS_W-1:0] src_z;
		logic signed [POS_W-1:0] lis_x;
		logic signed [POS_W-1:0] lis_y;
		logic signed [POS_W-1:0] lis_z;
		logic signed [AX_W-1:0] axis_x;
		logic signed [AX_W-1:0] axis_y;
		logic signed [AX_W-1:0] axis_z;
		logic narrow;
	} req_t;

	typedef struct packed {
		logic [GW-1:0] gain_a;
		logic [GW-1:0] gain_b;
		logic [5:0] volume;
	} res_t;
endpackage

// ----- hw/rtl/spdv_vol.sv -----
// Distance volume pipeline: squared distance, then compare against 2^36/v^2 thresholds.
`timescale 1ns / 1ps
module spdv_vol (
	input logic clk,
	input logic [18:0] ax,
	input logic [18:0] ay,
	input logic [18:0] az,
	input logic big,
	input logic en,
	output logic [5:0] volume
);
	logic [37:0] sq_x_s1, sq_y_s1, sq_z_s1;
	logic big_s1, big_s2;
	logic [39:0] s_s2;
	logic [5:0] vol_s3;
	logic [32:1] ge;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_x_s1 <= ax * ax;
			sq_y_s1 <= ay * ay;
			sq_z_s1 <= az * az;
			big_s1 <= big;
			s_s2 <= 40'(sq_x_s1) + 40'(sq_y_s1) + 40'(sq_z_s1);
			big_s2 <= big_s1;
		end
	end

	// ge[v]: v*v*s <= 2^36, i.e. s <= floor(2^36 / v^2)
	for (genvar v = 1; v <= 32; v++) begin : g_thr
		localparam logic [39:0] THR = 40'((64'(1) << 36) / 64'(v * v));
		assign ge[v] = s_s2 <= THR;
	end

	always_comb begin
		vol_s3 = '0;
		for (int v = 1; v <= 32; v++) begin
			if (ge[v]) vol_s3 = 6'(v);
		end
		if (big_s2) vol_s3 = '0;
	end

	always_ff @(posedge clk) begin
		if (en) volume <= vol_s3;
	end
endmodule

// ----- hw/rtl/stereo_pan_and_distance_volume.sv -----
// Top level: stereo pan and distance volume.
// Usage: present a request on req with start high; it is taken when busy is low.
// busy is always low, so one request may be taken every cycle.
// Each request gives one result on res, marked by done for one cycle,
// after it has passed through five registered stages:
// difference, products, sum/clamp, reciprocal divide and snap, gains/output.
// The volume path runs alongside: squares, sum of squares, threshold compare,
// then the shared output register.
// Throughput: one request per cycle, set by the fully pipelined multipliers.
// Reset clears all valid bits; no result appears until a request is taken.
// The receiver cannot stall; results are never held.
`timescale 1ns / 1ps
module stereo_pan_and_distance_volume (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input spdv_pkg::req_t req,
	output logic done,
	output spdv_pkg::res_t res
);
	localparam int DW = spdv_pkg::DW;
	localparam int PRW = spdv_pkg::PRW;
	localparam int GW = spdv_pkg::GW;
	localparam int GF = spdv_pkg::GF;
	localparam logic signed [PRW-1:0] TEN = PRW'(10) <<< spdv_pkg::PF;
	// ceil(2^26/5) and ceil(2^26/25): exact floor division for the ranges used here
	localparam logic [23:0] RCP5 = 24'd13421773;
	localparam logic [23:0] RCP25 = 24'd2684355;

	function automatic logic [19:0] div5(input logic [19:0] n);
		logic [43:0] m;
		m = 44'(n) * 44'(RCP5);
		return {2'b00, m[43:26]};
	endfunction

	logic [4:0] v_q;
	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;
	logic signed [spdv_pkg::AX_W-1:0] axx_s1, axy_s1, axz_s1;
	logic nar_s1, nar_s2, nar_s3;
	logic signed [PRW-1:0] px_s2, py_s2, pz_s2;
	logic signed [PRW-1:0] sum;
	logic signed [PRW-1:0] pc;
	logic signed [PRW-1:0] xn;
	logic [20:0] n_s3;
	logic [44:0] prod;
	logic [18:0] qt;
	logic [GW-1:0] p;
	logic [GW-1:0] p_s4, q_s4;
	logic [GW+1:0] ga_s4, gb_s4;
	logic [DW-1:0] mx, my, mz;
	logic big;
	logic [GW-1:0] pp, qq;
	logic snap;
	spdv_pkg::res_t r_q;
	logic [5:0] vol;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else v_q <= {v_q[3:0], start};
	end

	always_ff @(posedge clk) begin
		dx_s1 <= DW'(req.src_x) - DW'(req.lis_x);
		dy_s1 <= DW'(req.src_y) - DW'(req.lis_y);
		dz_s1 <= DW'(req.src_z) - DW'(req.lis_z);
		axx_s1 <= req.axis_x;
		axy_s1 <= req.axis_y;
		axz_s1 <= req.axis_z;
		nar_s1 <= req.narrow;
		px_s2 <= PRW'(dx_s1) * PRW'(axx_s1);
		py_s2 <= PRW'(dy_s1) * PRW'(axy_s1);
		pz_s2 <= PRW'(dz_s1) * PRW'(axz_s1);
		nar_s2 <= nar_s1;
	end

	// p = floor((x >> 8) / 5) wide, floor((y >> 8) / 25) narrow
	always_comb begin
		sum = px_s2 + py_s2 + pz_s2;
		pc = sum > TEN ? TEN : (sum < -TEN ? -TEN : sum);
		if (nar_s2) xn = 2 * pc + 5 * TEN;
		else xn = pc + TEN;
	end

	always_ff @(posedge clk) begin
		n_s3 <= xn[28:8];
		nar_s3 <= nar_s2;
	end

	always_comb begin
		prod = 45'(n_s3) * 45'(nar_s3 ? RCP25 : RCP5);
		qt = prod[44:26];
		p = qt > 19'(spdv_pkg::ONE) ? spdv_pkg::ONE : GW'(qt);
		pp = p;
		qq = spdv_pkg::ONE - p;
		snap = (32'(pp) * 100 >= 32'(spdv_pkg::ONE) * 49) &&
			(32'(pp) * 100 <= 32'(spdv_pkg::ONE) * 51) &&
			(32'(qq) * 100 >= 32'(spdv_pkg::ONE) * 49) &&
			(32'(qq) * 100 <= 32'(spdv_pkg::ONE) * 51);
		if (snap) begin
			pp = spdv_pkg::ONE >> 1;
			qq = spdv_pkg::ONE >> 1;
		end
	end

	always_ff @(posedge clk) begin
		p_s4 <= pp;
		q_s4 <= qq;
	end

	always_comb begin
		if (p_s4 < q_s4) begin
			ga_s4 = (GW+2)'(div5(20'(p_s4) << 3));
			gb_s4 = (GW+2)'(20'(q_s4) + div5(20'(spdv_pkg::ONE - q_s4) * 20'd3));
		end else begin
			ga_s4 = (GW+2)'(20'(p_s4) + div5(20'(spdv_pkg::ONE - p_s4) * 20'd3));
			gb_s4 = (GW+2)'(div5(20'(q_s4) << 3));
		end
	end

	assign mx = dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
	assign my = dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1);
	assign mz = dz_s1[DW-1] ? DW'(-dz_s1) : DW'(dz_s1);
	assign big = (mx > DW'(1 << 18)) || (my > DW'(1 << 18)) || (mz > DW'(1 << 18));

	spdv_vol u_vol (
		.clk(clk),
		.ax(mx[18:0]), .ay(my[18:0]), .az(mz[18:0]),
		.big(big), .en(1'b1), .volume(vol)
	);

	always_ff @(posedge clk) begin
		r_q.gain_a <= GW'(ga_s4);
		r_q.gain_b <= GW'(gb_s4);
		r_q.volume <= vol;
	end

	assign res = r_q;
	assign done = v_q[4];

	a_busy: assert property (@(posedge clk) busy == 1'b0) else $error("busy");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##5 done) else $error("latency");
	a_nostart: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!start, 5) && v_q[4] == 1'b0 |-> !done) else $error("spurious");
endmodule

// ----- bench/tb.sv -----
// Testbench: random and directed requests checked against a behavioral pan and volume predictor.
`timescale 1ns / 1ps
module tb;
	localparam int POS_W = spdv_pkg::POS_W;
	localparam int AX_W = spdv_pkg::AX_W;
	localparam int GW = spdv_pkg::GW;
	localparam int GF = spdv_pkg::GF;
	localparam int PF = spdv_pkg::PF;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	spdv_pkg::req_t req;
	logic done;
	spdv_pkg::res_t res;

	spdv_pkg::req_t pending_reqs[$];
	spdv_pkg::res_t expected_res[$];
	int errors;
	int cycles;
	int burst_left;
	int gap_left;
	bit hold_for_drain;

	stereo_pan_and_distance_volume i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .res(res)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [5:0] volume_of(longint dx, longint dy, longint dz);
		longint unsigned ax, ay, az, s;
		int v;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		az = dz < 0 ? -dz : dz;
		if (ax > (64'd1 << 18) || ay > (64'd1 << 18) || az > (64'd1 << 18))
			return 6'd0;
		s = ax * ax + ay * ay + az * az;
		if (s < (64'd1 << 26))
			return 6'd32;
		for (v = 32; v > 0; v--)
			if (longint'(v) * v * s <= (64'd1 << 36))
				return 6'(v);
		return 6'd0;
	endfunction

	function automatic spdv_pkg::res_t pan_gains(spdv_pkg::req_t r);
		longint dx, dy, dz, proj, ten;
		longint unsigned p, q, one, ga, gb;
		spdv_pkg::res_t o;
		ten = longint'(10) <<< PF;
		one = 64'd1 << GF;
		dx = longint'(r.src_x) - longint'(r.lis_x);
		dy = longint'(r.src_y) - longint'(r.lis_y);
		dz = longint'(r.src_z) - longint'(r.lis_z);
		proj = longint'(r.axis_x) * dx + longint'(r.axis_y) * dy + longint'(r.axis_z) * dz;
		if (proj > ten)
			proj = ten;
		else if (proj < -ten)
			proj = -ten;
		if (r.narrow)
			p = ($unsigned(2 * proj + 5 * ten) << GF) / (64'd100 << PF);
		else
			p = ($unsigned(proj + ten) << GF) / (64'd20 << PF);
		if (p > one)
			p = one;
		q = one - p;
		if (100 * p >= 49 * one && 100 * p <= 51 * one &&
				100 * q >= 49 * one && 100 * q <= 51 * one) begin
			p = one >> 1;
			q = one >> 1;
		end
		if (p < q) begin
			ga = (p * 8) / 5;
			gb = q + (3 * (one - q)) / 5;
		end else begin
			ga = p + (3 * (one - p)) / 5;
			gb = (q * 8) / 5;
		end
		o.gain_a = GW'(ga);
		o.gain_b = GW'(gb);
		o.volume = volume_of(dx, dy, dz);
		return o;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	function automatic logic signed [POS_W-1:0] rand_pos(int kind);
		case (kind)
			0: return POS_W'($urandom);
			1: return POS_W'($urandom_range(0, 8192)) - POS_W'(4096);
			2: return POS_W'($urandom_range(0, 600000)) - POS_W'(300000);
			default: return POS_W'($urandom_range(0, 20)) - POS_W'(10);
		endcase
	endfunction

	function automatic logic signed [AX_W-1:0] rand_axis(int kind);
		case (kind)
			0: return AX_W'($urandom);
			1: return AX_W'($urandom_range(0, 32768)) - AX_W'(16384);
			default: return AX_W'($urandom_range(0, 8)) - AX_W'(4);
		endcase
	endfunction

	function automatic spdv_pkg::req_t rand_req();
		spdv_pkg::req_t r;
		int k;
		k = $urandom_range(0, 3);
		r.lis_x = rand_pos($urandom_range(0, 3));
		r.lis_y = rand_pos($urandom_range(0, 3));
		r.lis_z = rand_pos($urandom_range(0, 3));
		r.src_x = (k == 0) ? rand_pos(0) : r.lis_x + rand_pos(k);
		r.src_y = (k == 0) ? rand_pos(0) : r.lis_y + rand_pos(k);
		r.src_z = (k == 0) ? rand_pos(0) : r.lis_z + rand_pos(k);
		r.axis_x = rand_axis($urandom_range(0, 2));
		r.axis_y = rand_axis($urandom_range(0, 2));
		r.axis_z = rand_axis($urandom_range(0, 2));
		r.narrow = $urandom_range(0, 1);
		return r;
	endfunction

	function automatic spdv_pkg::req_t mk(int sx, int sy, int sz, int lx, int ly, int lz,
			int ax, int ay, int az, bit nr);
		spdv_pkg::req_t r;
		r.src_x = POS_W'(sx); r.src_y = POS_W'(sy); r.src_z = POS_W'(sz);
		r.lis_x = POS_W'(lx); r.lis_y = POS_W'(ly); r.lis_z = POS_W'(lz);
		r.axis_x = AX_W'(ax); r.axis_y = AX_W'(ay); r.axis_z = AX_W'(az);
		r.narrow = nr;
		return r;
	endfunction

	// driver
	always @(negedge clk) begin
		if (!arst_n || hold_for_drain || pending_reqs.size() == 0) begin
			start <= 1'b0;
		end else if (start && busy) begin
			start <= 1'b1;
		end else if (gap_left > 0) begin
			start <= 1'b0;
			gap_left--;
		end else begin
			req <= pending_reqs.pop_front();
			start <= 1'b1;
			if (burst_left > 0)
				burst_left--;
			else begin
				burst_left = $urandom_range(0, 40);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		spdv_pkg::res_t want;
		if (arst_n) begin
			cycles++;
			if (start && !busy)
				expected_res.push_back(pan_gains(req));
			if (done) begin
				if (expected_res.size() == 0) begin
					report("unexpected result", 1, 0);
				end else begin
					want = expected_res.pop_front();
					if (res.gain_a !== want.gain_a)
						report("gain_a", res.gain_a, want.gain_a);
					if (res.gain_b !== want.gain_b)
						report("gain_b", res.gain_b, want.gain_b);
					if (res.volume !== want.volume)
						report("volume", res.volume, want.volume);
				end
			end
			if (cycles > 200000) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		int i;
		errors = 0;
		cycles = 0;
		burst_left = 0;
		gap_left = 0;
		hold_for_drain = 1'b0;
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		pending_reqs.push_back(mk(0, 0, 0, 0, 0, 0, 16384, 0, 0, 0));
		pending_reqs.push_back(mk(0, 0, 0, 0, 0, 0, 16384, 0, 0, 1));
		pending_reqs.push_back(mk(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
			16384, 16384, 16384, 0));
		pending_reqs.push_back(mk(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
			-16384, -16384, -16384, 1));
		pending_reqs.push_back(mk(2560, 0, 0, 0, 0, 0, 16384, 0, 0, 0));
		pending_reqs.push_back(mk(-2560, 0, 0, 0, 0, 0, 16384, 0, 0, 1));
		pending_reqs.push_back(mk(51, 0, 0, 0, 0, 0, 16384, 0, 0, 0));
		pending_reqs.push_back(mk(52, 0, 0, 0, 0, 0, 16384, 0, 0, 0));
		pending_reqs.push_back(mk(8192, 0, 0, 0, 0, 0, 0, 16384, 0, 0));
		pending_reqs.push_back(mk(8191, 0, 0, 0, 0, 0, 0, 0, 16384, 0));
		pending_reqs.push_back(mk(262144, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk(262145, 0, 0, 0, 0, 0, 0, 0, 0, 1));
		pending_reqs.push_back(mk(0, 20000, 0, 0, 0, 0, -32768, 32767, 0, 0));
		pending_reqs.push_back(mk(1000, 1000, 1000, 0, 0, 0, 9459, 9459, 9459, 1));
		pending_reqs.push_back(mk(-300, 0, 0, 0, 0, 0, 16384, 0, 0, 0));
		pending_reqs.push_back(mk(0, 0, 0, 0, 0, 0, -32768, -32768, -32768, 0));
		while (pending_reqs.size() != 0)
			@(negedge clk);
		hold_for_drain = 1'b1;
		while (expected_res.size() != 0)
			@(negedge clk);
		hold_for_drain = 1'b0;

		for (i = 0; i < 1350; i++) begin
			pending_reqs.push_back(rand_req());
			if (i == 600) begin
				while (pending_reqs.size() != 0)
					@(negedge clk);
				hold_for_drain = 1'b1;
				while (expected_res.size() != 0)
					@(negedge clk);
				hold_for_drain = 1'b0;
			end
		end
		while (pending_reqs.size() != 0)
			@(negedge clk);
		@(negedge clk);
		while (expected_res.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
